// File: hw/rtl/hcbd_pkg.sv
// Shared types and constants of the HTTP chunked body decoder.
package hcbd_pkg;

  // Width of the chunk-size / bytes-left counter.
  localparam int unsigned SIZE_BITS = 32;

  // Depth of the queue between the parser and the output stage.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Result kinds and outcomes.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;
  localparam logic OUTCOME_OK   = 1'b0;
  localparam logic OUTCOME_BAD  = 1'b1;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_end;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic       outcome;
  } out_item_t;

  // One classified input byte: an optional payload byte and an optional status.
  typedef struct packed {
    logic       pay_vld;
    logic [7:0] pay_byte;
    logic       end_vld;
    logic       bad;
  } entry_t;

endpackage

// File: hw/rtl/hcbd_front.sv
// Chunk-size line parser: classifies each body byte into a queue entry.
module hcbd_front import hcbd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     full_i,
  output logic     push_o,
  output entry_t   entry_o
);

  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChSemi = 8'h3B;

  typedef enum logic [3:0] {
    PH_START,
    PH_SIZE,
    PH_SIZE_CR,
    PH_EXT,
    PH_EXT_CR,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_DONE
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [SIZE_BITS-1:0]   count_q, count_d;
  logic                   flag_q, flag_d;

  logic                   accept;
  logic                   hex_ok;
  logic [3:0]             hex_val;
  logic                   dig_ovf;
  logic [7:0]             b;

  assign b          = in_data_i.body_byte;
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign dig_ovf    = (count_q[SIZE_BITS-1 -: 4] != 4'h0);

  // Hex digit decode.
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_val = 4'(b - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    flag_d  = flag_q;
    entry_o = '0;

    unique case (phase_q) inside
      PH_START, PH_SIZE: begin
        if (hex_ok) begin
          if (dig_ovf) begin
            flag_d  = 1'b1;
            phase_d = PH_DONE;
          end else begin
            count_d = {count_q[SIZE_BITS-5:0], hex_val};
            phase_d = PH_SIZE;
          end
        end else if (phase_q == PH_SIZE && b == ChSemi) begin
          phase_d = PH_EXT;
        end else if (phase_q == PH_SIZE && b == ChCr) begin
          phase_d = PH_SIZE_CR;
        end else begin
          flag_d  = 1'b1;
          phase_d = PH_DONE;
        end
      end
      PH_SIZE_CR: begin
        if (b == ChLf) begin
          phase_d = (count_q == '0) ? PH_DONE : PH_DATA;
        end else begin
          flag_d  = 1'b1;
          phase_d = PH_DONE;
        end
      end
      PH_EXT: begin
        if (b == ChCr) phase_d = PH_EXT_CR;
      end
      PH_EXT_CR: begin
        if (b == ChLf) begin
          phase_d = (count_q == '0) ? PH_DONE : PH_DATA;
        end else if (b != ChCr) begin
          phase_d = PH_EXT;
        end
      end
      PH_DATA: begin
        entry_o.pay_vld  = 1'b1;
        entry_o.pay_byte = b;
        count_d          = count_q - 1'b1;
        if (count_d == '0) phase_d = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        if (b == ChCr) begin
          phase_d = PH_DATA_LF;
        end else begin
          flag_d  = 1'b1;
          phase_d = PH_DONE;
        end
      end
      PH_DATA_LF: begin
        if (b == ChLf) begin
          phase_d = PH_START;
          count_d = '0;
        end else begin
          flag_d  = 1'b1;
          phase_d = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase

    // Last byte: report and return to the reset state.
    if (in_data_i.body_end) begin
      entry_o.end_vld = 1'b1;
      entry_o.bad     = (phase_d == PH_DONE) ? flag_d : OUTCOME_BAD;
      phase_d         = PH_START;
      count_d         = '0;
      flag_d          = 1'b0;
    end
  end

  assign push_o = accept && (entry_o.pay_vld || entry_o.end_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      count_q <= '0;
      flag_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      count_q <= count_d;
      flag_q  <= flag_d;
    end
  end

`ifndef SYNTHESIS
  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> count_q != '0)
    else $error("data phase with zero bytes left");
`endif

endmodule

// File: hw/rtl/hcbd_queue.sv
// Small FIFO of classified entries between parser and output stage.
module hcbd_queue import hcbd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   empty_o,
  output logic   full_o
);

  entry_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_q, rd_q;
  logic [QUEUE_CNT_W-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
`endif

endmodule

// File: hw/rtl/hcbd_back.sv
// Output stage: expands queue entries into result transfers.
module hcbd_back import hcbd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  entry_t    head_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic      out_vld_q, out_vld_d;
  out_item_t out_q, out_d;
  logic      half_q, half_d;
  logic      load;

  // The output register can take a new result when empty or being drained.
  assign load = (!out_vld_q || out_ready_i) && !empty_i;

  always_comb begin
    out_vld_d = out_vld_q && !out_ready_i;
    out_d     = out_q;
    half_d    = half_q;
    pop_o     = 1'b0;
    if (load) begin
      out_vld_d = 1'b1;
      if (head_i.pay_vld && !half_q) begin
        out_d.kind         = KIND_PAYLOAD;
        out_d.payload_byte = head_i.pay_byte;
        out_d.outcome      = OUTCOME_OK;
        if (head_i.end_vld) half_d = 1'b1;
        else                pop_o  = 1'b1;
      end else begin
        out_d.kind         = KIND_STATUS;
        out_d.payload_byte = 8'h00;
        out_d.outcome      = head_i.bad;
        half_d             = 1'b0;
        pop_o              = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      half_q    <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      half_q    <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_half_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> !empty_i && head_i.pay_vld && head_i.end_vld)
    else $error("split entry lost its head");
`endif

endmodule

// File: hw/rtl/http_chunked_body_decoder.sv
// A result passes through the queue and then the output register before it is offered.
// Throughput: one body byte per cycle while the queue is not full; a last byte that also
//   carries payload yields two result transfers, payload first and then status.
// The parser runs ahead of the output stage through a four-entry queue.
// Reset (rst_ni low, asynchronous): parser expects the first size digit,
//   queue and output register empty.
module http_chunked_body_decoder import hcbd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  // Queue link between parser and output stage.
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  entry_t entry;
  entry_t head;

  // Parser: take one byte per transfer, track the chunk-size line and data
  // count, and push an entry for every byte that yields a result.
  hcbd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (entry)
  );

  // Decouple the two sides so the parser keeps taking bytes while a result
  // waits for the consumer.
  hcbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  // Output stage: payload first, then status, from the registered result.
  hcbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/http_chunked_body_decoder_tb.sv
// Self-checking testbench for the HTTP chunked body decoder: directed and random bodies.
`timescale 1ns / 100ps

module http_chunked_body_decoder_tb;
  import hcbd_pkg::*;

  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned REPORT_LIMIT   = 10;

  // Framing characters of the chunked coding.
  localparam logic [7:0] CR   = 8'h0D;
  localparam logic [7:0] LF   = 8'h0A;
  localparam logic [7:0] SEMI = 8'h3B;

  // Where the parser stands within the current body.
  typedef enum logic [3:0] {
    PS_START,    // expecting the first digit of a size line
    PS_SIZE,     // inside the size digits
    PS_SIZE_CR,  // CR seen after the size, LF must follow
    PS_EXT,      // skipping a chunk extension
    PS_EXT_CR,   // CR seen inside the extension
    PS_DATA,     // passing chunk data through
    PS_DATA_CR,  // chunk data done, CR must follow
    PS_DATA_LF,  // CR after data seen, LF must follow
    PS_DONE      // end chunk seen or body malformed; ignore the rest
  } parse_state_e;

  // Ways of spoiling an otherwise well-formed body.
  typedef enum int {
    DAMAGE_FLIP,
    DAMAGE_CUT,
    DAMAGE_INSERT,
    DAMAGE_OVERFLOW,
    DAMAGE_HUGE_SIZE,
    DAMAGE_DATA_TAIL,
    DAMAGE_LONE_CR
  } damage_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  // Own copy of the parser state, advanced on every accepted input transfer.
  parse_state_e         parse_state = PS_START;
  logic [SIZE_BITS-1:0] size_left   = '0;
  logic                 malformed   = 1'b0;

  // Decoder output still owed by the block, oldest first.
  out_item_t decoded_due[$];
  out_item_t head_result;

  logic [7:0]  body_buf[$];
  int unsigned bytes_sent   = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;
  int unsigned stall_left   = 0;

  always #2 clk_i = ~clk_i;

  http_chunked_body_decoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // Latch malformed; everything up to the last byte is then ignored.
  task automatic flag_malformed();
    malformed   = 1'b1;
    parse_state = PS_DONE;
  endtask

  // Shift one hex digit into the size; refuse it if the top nibble is in use.
  task automatic take_size_nibble(input int nib);
    if (size_left[SIZE_BITS-1 -: 4] != '0) begin
      flag_malformed();
    end else begin
      size_left   = {size_left[SIZE_BITS-5:0], 4'(nib)};
      parse_state = PS_SIZE;
    end
  endtask

  // Advance the parser by one body byte and queue whatever it must produce.
  task automatic decode_body_byte(input in_item_t item);
    int         nib;
    logic [7:0] b;
    b   = item.body_byte;
    nib = hex_nibble(b);
    case (parse_state)
      PS_START: begin
        if (nib < 0) flag_malformed();
        else take_size_nibble(nib);
      end
      PS_SIZE: begin
        if (nib >= 0) take_size_nibble(nib);
        else if (b == SEMI) parse_state = PS_EXT;
        else if (b == CR) parse_state = PS_SIZE_CR;
        else flag_malformed();
      end
      PS_SIZE_CR: begin
        if (b == LF) parse_state = (size_left == '0) ? PS_DONE : PS_DATA;
        else flag_malformed();
      end
      PS_EXT: begin
        if (b == CR) parse_state = PS_EXT_CR;
      end
      PS_EXT_CR: begin
        // A CR inside an extension only closes the line when LF follows.
        if (b == LF) parse_state = (size_left == '0) ? PS_DONE : PS_DATA;
        else if (b != CR) parse_state = PS_EXT;
      end
      PS_DATA: begin
        decoded_due.push_back('{kind: KIND_PAYLOAD, payload_byte: b, outcome: OUTCOME_OK});
        size_left = size_left - 1'b1;
        if (size_left == '0) parse_state = PS_DATA_CR;
      end
      PS_DATA_CR: begin
        if (b == CR) parse_state = PS_DATA_LF;
        else flag_malformed();
      end
      PS_DATA_LF: begin
        if (b == LF) begin
          parse_state = PS_START;
          size_left   = '0;
        end else begin
          flag_malformed();
        end
      end
      default: ;
    endcase
    // The last byte always yields a status; a body cut short is malformed.
    if (item.body_end) begin
      decoded_due.push_back('{kind: KIND_STATUS, payload_byte: 8'h00,
                              outcome: (parse_state == PS_DONE) ? malformed : OUTCOME_BAD});
      parse_state = PS_START;
      size_left   = '0;
      malformed   = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking and watchdog
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t ns: %s: expected kind=%0d byte=%02h outcome=%0d, got kind=%0d byte=%02h outcome=%0d",
               $time, what, want.kind, want.payload_byte, want.outcome,
               got.kind, got.payload_byte, got.outcome);
    end
  endtask

  // Compare every output transfer with the oldest result still owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_due.size() == 0) begin
        report_mismatch("result with nothing outstanding", '0, out_data_o);
      end else begin
        head_result = decoded_due.pop_front();
        if (out_data_o.kind !== head_result.kind ||
            out_data_o.payload_byte !== head_result.payload_byte ||
            out_data_o.outcome !== head_result.outcome) begin
          report_mismatch("result mismatch", head_result, out_data_o);
        end
      end
    end
  end

  // Count cycles with no transfer on either side; give up when the block hangs.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: stall in random bursts while stall_pct is non-zero.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
      out_ready_i = 1'b0;
      stall_left  = $urandom_range(7, 0);
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(255, 0));
  endfunction

  // Hex digit for d, letters in either case.
  function automatic logic [7:0] hex_char(input int unsigned d);
    if (d < 10) return 8'("0" + d);
    return 8'((($urandom_range(1, 0) != 0) ? "A" : "a") + d - 10);
  endfunction

  // Choose idling for the next body; a quarter of the time leave a side busy-free.
  task automatic pick_idling();
    gap_pct   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 5);
    stall_pct = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 5);
  endtask

  // Offer one byte; hold it until the transfer happens, then predict.
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk_i);
    if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(8, 1)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = '{body_byte: b, body_end: last};
    do @(posedge clk_i); while (!in_ready_o);
    decode_body_byte(in_data_i);
    bytes_sent++;
  endtask

  task automatic send_body();
    foreach (body_buf[i]) send_byte(body_buf[i], i == body_buf.size() - 1);
  endtask

  // Append a size line: optional leading zeros, the size in hex, maybe an extension.
  task automatic append_size_line(input int unsigned len);
    logic [7:0]  digits[$];
    int unsigned rest;
    logic [7:0]  c;
    if ($urandom_range(3, 0) == 0) repeat ($urandom_range(9, 1)) body_buf.push_back("0");
    rest = len;
    do begin
      digits.push_front(hex_char(rest % 16));
      rest = rest / 16;
    end while (rest != 0);
    foreach (digits[i]) body_buf.push_back(digits[i]);
    if ($urandom_range(2, 0) == 0) begin
      body_buf.push_back(SEMI);
      repeat ($urandom_range(5, 0)) begin
        c = any_byte();
        body_buf.push_back(c);
        // Keep a stray CR from ending the line early: follow it with text.
        if (c == CR) begin
          if ($urandom_range(1, 0) == 0) body_buf.push_back(CR);
          body_buf.push_back("x");
        end
      end
    end
    body_buf.push_back(CR);
    body_buf.push_back(LF);
  endtask

  // Zero to three data chunks, the end chunk, then a few ignored trailing bytes.
  task automatic build_good_body();
    int unsigned len;
    body_buf.delete();
    repeat ($urandom_range(3, 0)) begin
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
      append_size_line(len);
      repeat (len) body_buf.push_back(any_byte());
      body_buf.push_back(CR);
      body_buf.push_back(LF);
    end
    append_size_line(0);
    repeat ($urandom_range(3, 0)) body_buf.push_back(any_byte());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    gap_pct   = 20;
    stall_pct = 20;
    // Extension holding a lone CR, a zero payload byte, a trailing byte after the end chunk.
    body_buf = {"1", SEMI, CR, "x", CR, LF, 8'h00, CR, LF, "0", CR, LF, 8'hFF};
    send_body();
    // Bad first digit.
    body_buf = {"G"};
    send_body();
    // Empty size field.
    body_buf = {CR};
    send_body();
    // Lone CR on a size line.
    body_buf = {"1", CR, "X"};
    send_body();
    // Early end on a payload byte: the byte comes out, then the status.
    body_buf = {"1", CR, LF, 8'hFF};
    send_body();
    // Chunk data not followed by CRLF.
    body_buf = {"1", CR, LF, "a", "b"};
    send_body();
  endtask

  task automatic test_wellformed_bodies();
    while (bytes_sent < 650) begin
      pick_idling();
      build_good_body();
      send_body();
    end
  endtask

  task automatic test_malformed_bodies();
    damage_e     damage;
    int unsigned pos;
    int unsigned len;
    logic [7:0]  b;
    while (bytes_sent < 1000) begin
      pick_idling();
      damage = damage_e'($urandom_range(int'(DAMAGE_LONE_CR), int'(DAMAGE_FLIP)));
      build_good_body();
      pos = $urandom_range(body_buf.size() - 1, 0);
      case (damage)
        DAMAGE_FLIP:   body_buf[pos] = any_byte();
        DAMAGE_CUT:    while (body_buf.size() > pos + 1) void'(body_buf.pop_back());
        DAMAGE_INSERT: body_buf.insert(pos, any_byte());
        DAMAGE_OVERFLOW: begin
          // Nine or more significant digits cannot fit the counter.
          body_buf.delete();
          body_buf.push_back(hex_char($urandom_range(15, 1)));
          repeat ($urandom_range(10, 8)) body_buf.push_back(hex_char($urandom_range(15, 0)));
          repeat ($urandom_range(3, 0)) body_buf.push_back(any_byte());
        end
        DAMAGE_HUGE_SIZE: begin
          // Full-width size, then the body stops after a few data bytes.
          body_buf.delete();
          body_buf.push_back(hex_char($urandom_range(15, 1)));
          repeat (7) body_buf.push_back(hex_char($urandom_range(15, 0)));
          body_buf.push_back(CR);
          body_buf.push_back(LF);
          repeat ($urandom_range(5, 1)) body_buf.push_back(any_byte());
        end
        DAMAGE_DATA_TAIL: begin
          // Chunk data followed by something other than CRLF.
          body_buf.delete();
          len = $urandom_range(4, 1);
          append_size_line(len);
          repeat (len) body_buf.push_back(any_byte());
          if ($urandom_range(1, 0) == 0) begin
            body_buf.push_back(CR);
            do b = any_byte(); while (b == LF);
          end else begin
            do b = any_byte(); while (b == CR);
          end
          body_buf.push_back(b);
          repeat ($urandom_range(3, 0)) body_buf.push_back(any_byte());
        end
        default: begin
          // Size line whose CR is not followed by LF.
          body_buf.delete();
          body_buf.push_back(hex_char($urandom_range(15, 0)));
          body_buf.push_back(CR);
          do b = any_byte(); while (b == LF);
          body_buf.push_back(b);
          repeat ($urandom_range(2, 0)) body_buf.push_back(any_byte());
        end
      endcase
      send_body();
    end
  endtask

  task automatic test_noise_bodies();
    repeat (12) begin
      pick_idling();
      body_buf.delete();
      repeat ($urandom_range(5, 1)) body_buf.push_back(any_byte());
      send_body();
    end
  endtask

  // Close with back-to-back transfers and no stalls at all.
  task automatic test_steady_stream();
    gap_pct   = 0;
    stall_pct = 0;
    repeat (5) begin
      build_good_body();
      send_body();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_wellformed_bodies();
    test_malformed_bodies();
    test_noise_bodies();
    test_steady_stream();

    // Drop valid, wait for every owed result, then watch a while for strays.
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (decoded_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && decoded_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
